// File: design/assert_macros.svh
// Assertion macros used by the checker file of the design.
// No dependencies; each macro clocks on the rising edge and is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CHK_ALWAYS(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) \
    else $error("check failed");

// Implication from an antecedent to a consequent.
`define CHK_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// File: design/smm_pkg.sv
// Package of the square matrix multiplier: beat types and default sizes.
// Used by the cell, the top level and the checker; no dependencies.
`timescale 1ns / 1ps
package smm_pkg;

  localparam int DEF_MAX_DIM    = 8;
  localparam int DEF_ELEM_WIDTH = 32;

  // Input beat: one element of A and the element of B at the same place.
  typedef struct packed {
    logic signed [31:0] a_elem;
    logic signed [31:0] b_elem;
  } in_beat_t;

  // Output beat: one product element with its position.
  typedef struct packed {
    logic signed [63:0] prod_elem;
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic               last;
  } out_beat_t;

  // Control that travels with an element of A along the cell chain.
  typedef struct packed {
    logic vld;
    logic first;
  } tok_t;

endpackage

// File: design/smm_cell.sv
// One multiply-accumulate cell of the chain; holds one column of B.
// Depends on smm_pkg for the token type.
`timescale 1ns / 1ps
module smm_cell import smm_pkg::*; #(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH,
  parameter int KW         = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [KW-1:0]         wr_addr,
  input  logic [ELEM_WIDTH-1:0] wr_data,
  input  tok_t                  tok_in,
  input  logic [KW-1:0]         k_in,
  input  logic [ELEM_WIDTH-1:0] a_in,
  output tok_t                  tok_out,
  output logic [KW-1:0]         k_out,
  output logic [ELEM_WIDTH-1:0] a_out,
  output logic signed [63:0]    acc
);

  localparam int BD = 1 << KW;

  logic [ELEM_WIDTH-1:0]         bcol [BD];
  logic signed [2*ELEM_WIDTH-1:0] prod_w;
  logic signed [63:0]            prod;
  logic                          prod_v;
  logic                          prod_first;

  // Column store of B, written while loading.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bcol[wr_addr] <= wr_data;
    end
  end

  assign prod_w = $signed(a_in) * $signed(bcol[k_in]);

  // Hand the element of A to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    k_out <= k_in;
    a_out <= a_in;
  end

  // Product stage, then accumulate; the first term of a row restarts the sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= tok_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    prod       <= 64'(prod_w);
    prod_first <= tok_in.first;
    if (prod_v) begin
      acc <= prod_first ? prod : acc + prod;
    end
  end

endmodule

// File: design/square_matrix_multiplier.sv
// Top level of the square matrix multiplier: load control, A memory, cell chain, output.
// Depends on smm_pkg and smm_cell.
`timescale 1ns / 1ps
// Loads dim x dim matrices A and B one element pair per cycle in row-major order,
// dim = 2^size_log2 limited to MAX_DIM. After the last pair the block computes
// C = A * B modulo 2^64 one row at a time on a chain of MAX_DIM cells, one per
// column: each row streams A through the chain, waits while the chain drains,
// and then gives dim output beats. No input is taken while a product is being
// computed or emitted; the final output beat may still wait in the output register
// while the next load begins. Writing size_log2 restarts any partial load.
module square_matrix_multiplier import smm_pkg::*; #(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_beat_t    in_beat,
  output logic        out_valid,
  input  logic        out_ready,
  output out_beat_t   out_beat,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int KW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int LOG_MAX = $clog2(MAX_DIM);
  localparam int LAT     = MAX_DIM + 2;
  localparam int DW      = $clog2(LAT + 1);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  localparam logic [0:0] REG_SIZE = 1'b0;

  logic [1:0]    size_log2;
  logic [1:0]    s_eff;
  logic [KW:0]   pow;
  logic [KW:0]   dim;
  logic [KW:0]   dim_m1;
  logic [1:0]    state;
  logic [KW-1:0] lr, lc, r, k, ec;
  logic [DW-1:0] dcnt;
  logic          cfg_wr;
  logic          in_acc;
  logic          emit_go;

  logic [ELEM_WIDTH-1:0] amem [1 << (2*KW)];
  logic [ELEM_WIDTH-1:0] a_rd;
  tok_t                  tok0;
  logic [KW-1:0]         k0;

  tok_t                  toks [MAX_DIM+1];
  logic [KW-1:0]         ks   [MAX_DIM+1];
  logic [ELEM_WIDTH-1:0] as_  [MAX_DIM+1];
  logic signed [63:0]    accs [MAX_DIM];

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SIZE);
  assign prdata = (paddr[2] == REG_SIZE) ? {30'd0, size_log2} : 32'd0;

  // Dimension in use, saturated at the built maximum.
  assign s_eff  = (int'(size_log2) > LOG_MAX) ? 2'(LOG_MAX) : size_log2;
  assign pow    = (KW+1)'(1) << s_eff;
  assign dim    = (int'(pow) > MAX_DIM) ? (KW+1)'(MAX_DIM) : pow;
  assign dim_m1 = dim - (KW+1)'(1);

  assign in_ready = (state == ST_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign emit_go  = (state == ST_EMIT) && (!out_valid || out_ready);

  // Sequencer: load, stream rows of A, wait for the chain, emit a row.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2 <= 2'd3;
      state     <= ST_LOAD;
      lr        <= '0;
      lc        <= '0;
      r         <= '0;
      k         <= '0;
      ec        <= '0;
      dcnt      <= '0;
    end else if (cfg_wr) begin
      size_log2 <= pwdata[1:0];
      lr        <= '0;
      lc        <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if ({1'b0, lc} == dim_m1) begin
              lc <= '0;
              if ({1'b0, lr} == dim_m1) begin
                lr    <= '0;
                r     <= '0;
                k     <= '0;
                state <= ST_RUN;
              end else begin
                lr <= lr + 1'b1;
              end
            end else begin
              lc <= lc + 1'b1;
            end
          end
        end
        ST_RUN: begin
          if ({1'b0, k} == dim_m1) begin
            dcnt  <= '0;
            state <= ST_DRAIN;
          end else begin
            k <= k + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (dcnt == DW'(LAT - 1)) begin
            ec    <= '0;
            state <= ST_EMIT;
          end else begin
            dcnt <= dcnt + 1'b1;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            if ({1'b0, ec} == dim_m1) begin
              if ({1'b0, r} == dim_m1) begin
                state <= ST_LOAD;
              end else begin
                r     <= r + 1'b1;
                k     <= '0;
                state <= ST_RUN;
              end
            end else begin
              ec <= ec + 1'b1;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // A memory, written while loading and read one element per cycle.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      amem[{lr, lc}] <= in_beat.a_elem[ELEM_WIDTH-1:0];
    end
    a_rd <= amem[{r, k}];
    k0   <= k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok0 <= '0;
    end else begin
      tok0.vld   <= (state == ST_RUN);
      tok0.first <= (k == '0);
    end
  end

  assign toks[0] = tok0;
  assign ks[0]   = k0;
  assign as_[0]  = a_rd;

  // Chain of cells, one per column of B.
  for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
    smm_cell #(
      .MAX_DIM    (MAX_DIM),
      .ELEM_WIDTH (ELEM_WIDTH),
      .KW         (KW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .wr_en   (in_acc && (int'(lc) == c)),
      .wr_addr (lr),
      .wr_data (in_beat.b_elem[ELEM_WIDTH-1:0]),
      .tok_in  (toks[c]),
      .k_in    (ks[c]),
      .a_in    (as_[c]),
      .tok_out (toks[c+1]),
      .k_out   (ks[c+1]),
      .a_out   (as_[c+1]),
      .acc     (accs[c])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_beat.prod_elem <= accs[ec];
      out_beat.out_row   <= 3'(r);
      out_beat.out_col   <= 3'(ec);
      out_beat.last      <= ({1'b0, r} == dim_m1) && ({1'b0, ec} == dim_m1);
    end
  end

endmodule

// File: design/smm_checker.sv
// Port-level checks for the square matrix multiplier, bound to the top level.
// Depends on smm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module smm_checker import smm_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input out_beat_t   out_beat,
  input logic        pready
);

  // A stalled output beat holds.
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_beat))
  // No loading while a product row other than the final beat waits.
  `CHK_IMPL(a_busy, clk, rst, out_valid && !out_beat.last, !in_ready)
  // The final element sits on the diagonal.
  `CHK_IMPL(a_last_diag, clk, rst, out_valid && out_beat.last,
            out_beat.out_row == out_beat.out_col)
  // The port never stalls a register access.
  `CHK_ALWAYS(a_pready, clk, rst, pready)

endmodule

bind square_matrix_multiplier smm_checker u_smm_checker (.*);
